FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the engine top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked outside reset
`define ASSERT_CHK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CHK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: hw/rtl/frse_pkg.sv
package frse_pkg;

   // tree geometry
   localparam int SLOTS    = 1024;
   localparam int ADDR_W   = $clog2(SLOTS);
   localparam int SLOT_W   = 11;
   localparam int POS_W    = SLOT_W + 1;
   localparam int ENTRY_W  = 32;
   localparam int ACC_W    = 36;
   localparam int TOTAL_W  = 27;
   localparam int AMOUNT_W = 17;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANK  = 2'd2;

   // saturation limits of prefix_total
   localparam logic signed [ACC_W-1:0] TOTAL_MAX = 36'sd67108863;
   localparam logic signed [ACC_W-1:0] TOTAL_MIN = -36'sd67108864;

   // tree memory control
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic [ADDR_W-1:0]  rd_addr;
   } ram_ctl_type;

   // saturate a running sum to the result width
   function automatic logic signed [TOTAL_W-1:0] clamp_total(
      input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] lim;
      lim = x;
      if (x > TOTAL_MAX) lim = TOTAL_MAX;
      if (x < TOTAL_MIN) lim = TOTAL_MIN;
      return lim[TOTAL_W-1:0];
   endfunction

   // lowest set bit of a tree position
   function automatic logic [POS_W-1:0] low_bit(input logic [POS_W-1:0] p);
      return p & (~p + POS_W'(1));
   endfunction

endpackage

FILE: hw/rtl/frse_channels.sv
// request channel
interface frse_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [frse_pkg::ACTION_W-1:0]         action;
   logic [frse_pkg::SLOT_W-1:0]           index;
   logic signed [frse_pkg::AMOUNT_W-1:0]  amount;

   modport source(output valid, action, index, amount, input ready);
   modport sink(input valid, action, index, amount, output ready);
endinterface

// response channel
interface frse_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [frse_pkg::TOTAL_W-1:0]   prefix_total;
   logic [frse_pkg::SLOT_W-1:0]           found_slot;
   logic [frse_pkg::STATUS_W-1:0]         status;

   modport source(output valid, prefix_total, found_slot, status, input ready);
   modport sink(input valid, prefix_total, found_slot, status, output ready);
endinterface

FILE: hw/rtl/frse_tree_ram.sv
module frse_tree_ram (
   input  logic                           clock,
   input  frse_pkg::ram_ctl_type          ctl,
   output logic [frse_pkg::ENTRY_W-1:0]   rd_data
);

   logic [frse_pkg::ENTRY_W-1:0] mem [frse_pkg::SLOTS];
   logic [frse_pkg::ENTRY_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/frse_alu.sv
module frse_alu (
   input  logic signed [frse_pkg::ACC_W-1:0]    base,
   input  logic signed [frse_pkg::ENTRY_W-1:0]  addend,
   input  logic signed [frse_pkg::AMOUNT_W-1:0] rank,
   output logic signed [frse_pkg::ACC_W-1:0]    sum,
   output logic                                 below
);

   // shared adder and rank compare
   assign sum   = base + frse_pkg::ACC_W'(addend);
   assign below = sum < frse_pkg::ACC_W'(rank);

endmodule

FILE: hw/rtl/fenwick_rank_select_engine_top.sv
// sequence: add reads then writes each touched tree entry (up to 11 entries), query reads
// and accumulates one entry per set bit of index, select reads and compares at each probed
// level and skips a level whose probe lies past the last slot (11 levels), then walks the
// prefix of the found slot; a FINISH state loads the result. throughput: one item at a time,
// set by the single memory read port and shared adder; a result not yet taken holds the next.
// reset: synchronous; a clearing pass zeroes the tree before the first item.
`include "assert_macros.svh"

module fenwick_rank_select_engine_top (
   input  logic         clock,
   input  logic         reset,
   frse_req_if.sink     req_port,
   frse_rsp_if.source   rsp_port
);

   typedef enum logic [3:0] {
      CLEAR, IDLE, UPD_RD, UPD_WR, PRE_RD, PRE_ACC, SEL_RD, SEL_USE, FINISH
   } state_type;

   localparam logic [frse_pkg::POS_W-1:0]  SLOTS_POS = frse_pkg::POS_W'(frse_pkg::SLOTS);
   // largest power of two not above the slot count
   localparam logic [frse_pkg::SLOT_W-1:0] STEP_TOP  =
      frse_pkg::SLOT_W'(2 ** ($clog2(frse_pkg::SLOTS + 1) - 1));
   localparam logic [frse_pkg::ADDR_W-1:0] LAST_ADDR = frse_pkg::ADDR_W'(frse_pkg::SLOTS - 1);

   state_type                               state_ff, state_in;
   logic [frse_pkg::ADDR_W-1:0]             clr_cnt_ff, clr_cnt_in;
   logic [frse_pkg::POS_W-1:0]              pos_ff, pos_in;
   logic [frse_pkg::SLOT_W-1:0]             step_ff, step_in;
   logic signed [frse_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic signed [frse_pkg::AMOUNT_W-1:0]    amount_ff, amount_in;
   logic [frse_pkg::SLOT_W-1:0]             found_ff, found_in;
   logic [frse_pkg::STATUS_W-1:0]           status_ff, status_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [frse_pkg::TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [frse_pkg::SLOT_W-1:0]             rsp_found_ff, rsp_found_in;
   logic [frse_pkg::STATUS_W-1:0]           rsp_status_ff, rsp_status_in;

   frse_pkg::ram_ctl_type                   ram_ctl;
   logic [frse_pkg::ENTRY_W-1:0]            rd_data;
   logic signed [frse_pkg::ACC_W-1:0]       alu_base;
   logic signed [frse_pkg::ENTRY_W-1:0]     alu_addend;
   logic signed [frse_pkg::ACC_W-1:0]       alu_sum;
   logic                                    alu_below;
   logic [frse_pkg::POS_W-1:0]              sel_nxt;
   logic [frse_pkg::POS_W-1:0]              addr_pos;
   logic                                    req_accept;

   // tree memory
   frse_tree_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (rd_data)
   );

   // shared adder and compare
   frse_alu u_alu (
      .base   (alu_base),
      .addend (alu_addend),
      .rank   (amount_ff),
      .sum    (alu_sum),
      .below  (alu_below)
   );

   assign req_port.ready = (state_ff == IDLE);
   assign req_accept     = req_port.valid && req_port.ready;

   // select probe position and memory address
   assign sel_nxt  = pos_ff + frse_pkg::POS_W'(step_ff);
   assign addr_pos = (state_ff == SEL_RD || state_ff == SEL_USE) ? sel_nxt : pos_ff;

   // operand select for the shared unit
   always_comb begin
      if (state_ff == UPD_WR) begin
         alu_base   = frse_pkg::ACC_W'($signed(rd_data));
         alu_addend = frse_pkg::ENTRY_W'(amount_ff);
      end else begin
         alu_base   = acc_ff;
         alu_addend = $signed(rd_data);
      end
   end

   // sequencer
   always_comb begin
      logic                        sel_finish;
      logic [frse_pkg::POS_W-1:0]  sel_pos;
      logic [frse_pkg::POS_W-1:0]  pos_step;

      sel_finish    = 1'b0;
      sel_pos       = pos_ff;
      pos_step      = '0;
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      amount_in     = amount_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      ram_ctl.wr_en   = 1'b0;
      ram_ctl.rd_addr = frse_pkg::ADDR_W'(addr_pos - frse_pkg::POS_W'(1));
      ram_ctl.wr_addr = ram_ctl.rd_addr;
      ram_ctl.wr_data = alu_sum[frse_pkg::ENTRY_W-1:0];

      // result taken downstream
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         CLEAR: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = clr_cnt_ff;
            ram_ctl.wr_data = '0;
            clr_cnt_in      = clr_cnt_ff + frse_pkg::ADDR_W'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_accept) begin
               acc_in    = '0;
               found_in  = '0;
               status_in = frse_pkg::STAT_OK;
               amount_in = req_port.amount;
               pos_in    = frse_pkg::POS_W'(req_port.index);
               step_in   = STEP_TOP;
               case (req_port.action)
                  frse_pkg::ACT_ADD: begin
                     if (req_port.index == '0 ||
                         frse_pkg::POS_W'(req_port.index) > SLOTS_POS) begin
                        status_in = frse_pkg::STAT_RANGE;
                        state_in  = FINISH;
                     end else begin
                        state_in = UPD_RD;
                     end
                  end
                  frse_pkg::ACT_QUERY: begin
                     if (frse_pkg::POS_W'(req_port.index) > SLOTS_POS) begin
                        status_in = frse_pkg::STAT_RANGE;
                        state_in  = FINISH;
                     end else if (req_port.index == '0) begin
                        state_in = FINISH;
                     end else begin
                        state_in = PRE_RD;
                     end
                  end
                  frse_pkg::ACT_SELECT: begin
                     pos_in   = '0;
                     state_in = SEL_RD;
                  end
                  default: begin
                     state_in = FINISH;
                  end
               endcase
            end
         end
         UPD_RD: begin
            state_in = UPD_WR;
         end
         UPD_WR: begin
            ram_ctl.wr_en = 1'b1;
            pos_step      = pos_ff + frse_pkg::low_bit(pos_ff);
            pos_in        = pos_step;
            state_in      = (pos_step > SLOTS_POS) ? FINISH : UPD_RD;
         end
         PRE_RD: begin
            state_in = PRE_ACC;
         end
         PRE_ACC: begin
            acc_in   = alu_sum;
            pos_step = pos_ff & (pos_ff - frse_pkg::POS_W'(1));
            pos_in   = pos_step;
            state_in = (pos_step == '0) ? FINISH : PRE_RD;
         end
         SEL_RD: begin
            if (sel_nxt <= SLOTS_POS) begin
               state_in = SEL_USE;
            end else begin
               step_in = step_ff >> 1;
               if (step_ff == frse_pkg::SLOT_W'(1)) begin
                  sel_finish = 1'b1;
               end
            end
         end
         SEL_USE: begin
            if (alu_below) begin
               pos_in  = sel_nxt;
               acc_in  = alu_sum;
               sel_pos = sel_nxt;
            end
            step_in = step_ff >> 1;
            if (step_ff == frse_pkg::SLOT_W'(1)) begin
               sel_finish = 1'b1;
            end else begin
               state_in = SEL_RD;
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = frse_pkg::clamp_total(acc_ff);
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // end of the descent: walk the prefix of the found slot, or flag a rank error if none fits
      if (sel_finish) begin
         acc_in = '0;
         if (sel_pos == SLOTS_POS) begin
            status_in = frse_pkg::STAT_RANK;
            state_in  = FINISH;
         end else begin
            pos_in   = sel_pos + frse_pkg::POS_W'(1);
            found_in = frse_pkg::SLOT_W'(sel_pos + frse_pkg::POS_W'(1));
            state_in = PRE_RD;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      amount_ff     <= amount_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.prefix_total = rsp_total_ff;
   assign rsp_port.found_slot   = rsp_found_ff;
   assign rsp_port.status       = rsp_status_ff;

   // checks
   `ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid_ff && state_ff == CLEAR)
   `ASSERT_CHK(a_write_owner, clock, reset,
      ram_ctl.wr_en |-> state_ff == CLEAR || state_ff == UPD_WR)
   `ASSERT_CHK(a_busy_after_accept, clock, reset, req_accept |=> !req_port.ready)
   `ASSERT_CHK(a_found_ok, clock, reset,
      rsp_valid_ff && rsp_found_ff != '0 |-> rsp_status_ff == frse_pkg::STAT_OK)
   `ASSERT_CHK(a_error_zero, clock, reset,
      rsp_valid_ff && rsp_status_ff != frse_pkg::STAT_OK |->
         rsp_total_ff == '0 && rsp_found_ff == '0)
   `ASSERT_CHK(a_walk_range, clock, reset,
      state_ff == PRE_RD |-> pos_ff != '0 && pos_ff <= SLOTS_POS)

endmodule
